// ===== sv/crcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfp_pkg
// Shared types, constants and the CRC-16 byte step for the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfp_pkg;

  localparam int unsigned CountW = 10;
  localparam int unsigned IdLen  = 6;

  localparam logic [7:0]  MarkerReset = 8'hAA;
  localparam logic [7:0]  DistCmd     = 8'd44;
  localparam logic [31:0] DistLimit   = 32'd25000;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_FLAGS_LO = 3'd1,
    PH_FLAGS_HI = 3'd2,
    PH_CMD      = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_CRC_LO   = 3'd5,
    PH_CRC_HI   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_IGNORED  = 2'd0,
    KIND_IDENTITY = 2'd1,
    KIND_DISTANCE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  command_id;
    logic [6:0]  payload_length;
    logic [14:0] distance_cm;
    logic        sensor_verified;
  } result_t;

  // CRC-16, polynomial 0x1021, one byte per call, nibble-table-free form.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] code;
    code = crc[15:8] ^ b;
    code = code ^ {4'b0000, code[7:4]};
    return {crc[7:0], 8'h00} ^ {code[3:0], 12'h000} ^ {3'b000, code, 5'b00000}
           ^ {8'h00, code};
  endfunction

  // Identity text expected at the start of the payload.
  function automatic logic [7:0] id_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h46;
      3'd3:    c = 8'h32;
      3'd4:    c = 8'h35;
      3'd5:    c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/crcfp_in_reg.sv =====
// ----------------------------------------------------------------------------
// crcfp_in_reg
// Input register for received bytes; holds a beat until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfp_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       take,
  output logic            hold_valid,
  output logic [7:0]      hold_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r,  byte_nxt;

  assign in_stall   = valid_r && !take;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (take) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && !in_stall) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/crcfp_parser.sv =====
// ----------------------------------------------------------------------------
// crcfp_parser
// Frame state machine: CRC accumulation, field capture and result decision.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfp_parser #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  start_marker,
  output logic             res_valid,
  output crcfp_pkg::result_t res
);

  localparam int unsigned CW = crcfp_pkg::CountW;
  localparam logic [CW:0] BodyMax = (CW + 1)'(MAX_PAYLOAD + 1);

  crcfp_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0] body_r,     body_nxt;
  logic [CW-1:0] count_r,    count_nxt;
  logic [7:0]    cmd_r,      cmd_nxt;
  logic [15:0]   crc_r,      crc_nxt;
  logic [7:0]    crc_lo_r,   crc_lo_nxt;
  logic          id_match_r, id_match_nxt;
  logic [31:0]   dist_r,     dist_nxt;
  logic          verified_r, verified_nxt;

  logic [CW-1:0] count_inc;
  logic [CW-1:0] plen;

  assign count_inc = count_r + CW'(1);
  assign plen      = body_r - CW'(1);

  always_comb begin
    phase_nxt    = phase_r;
    body_nxt     = body_r;
    count_nxt    = count_r;
    cmd_nxt      = cmd_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    id_match_nxt = id_match_r;
    dist_nxt     = dist_r;
    verified_nxt = verified_r;
    res_valid    = 1'b0;
    res.kind            = crcfp_pkg::KIND_IGNORED;
    res.command_id      = cmd_r;
    res.payload_length  = plen[6:0];
    res.distance_cm     = 15'd0;
    res.sensor_verified = verified_r;

    case (phase_r)
      crcfp_pkg::PH_FLAGS_LO: begin
        crc_nxt   = crcfp_pkg::crc_step(crc_r, rx_byte);
        body_nxt  = {{(CW-2){1'b0}}, rx_byte[7:6]};
        phase_nxt = crcfp_pkg::PH_FLAGS_HI;
      end
      crcfp_pkg::PH_FLAGS_HI: begin
        crc_nxt  = crcfp_pkg::crc_step(crc_r, rx_byte);
        body_nxt = {rx_byte, body_r[1:0]};
        if (body_nxt == '0 || {1'b0, body_nxt} > BodyMax) begin
          phase_nxt = crcfp_pkg::PH_HUNT;
          body_nxt  = '0;
          count_nxt = '0;
        end else begin
          phase_nxt = crcfp_pkg::PH_CMD;
        end
      end
      crcfp_pkg::PH_CMD: begin
        crc_nxt      = crcfp_pkg::crc_step(crc_r, rx_byte);
        cmd_nxt      = rx_byte;
        count_nxt    = '0;
        id_match_nxt = 1'b1;
        dist_nxt     = '0;
        phase_nxt    = (body_r > CW'(1)) ? crcfp_pkg::PH_PAYLOAD : crcfp_pkg::PH_CRC_LO;
      end
      crcfp_pkg::PH_PAYLOAD: begin
        crc_nxt = crcfp_pkg::crc_step(crc_r, rx_byte);
        if (count_r < CW'(crcfp_pkg::IdLen)
            && rx_byte != crcfp_pkg::id_char(count_r[2:0])) begin
          id_match_nxt = 1'b0;
        end
        // The distance word is little endian in the first four payload bytes.
        if (count_r < CW'(4)) begin
          case (count_r[1:0])
            2'd0:    dist_nxt[7:0]   = rx_byte;
            2'd1:    dist_nxt[15:8]  = rx_byte;
            2'd2:    dist_nxt[23:16] = rx_byte;
            default: dist_nxt[31:24] = rx_byte;
          endcase
        end
        count_nxt = count_inc;
        if ({1'b0, count_inc} + (CW + 1)'(1) >= {1'b0, body_r}) begin
          phase_nxt = crcfp_pkg::PH_CRC_LO;
        end
      end
      crcfp_pkg::PH_CRC_LO: begin
        crc_lo_nxt = rx_byte;
        phase_nxt  = crcfp_pkg::PH_CRC_HI;
      end
      crcfp_pkg::PH_CRC_HI: begin
        phase_nxt = crcfp_pkg::PH_HUNT;
        body_nxt  = '0;
        count_nxt = '0;
        if ({rx_byte, crc_lo_r} == crc_r) begin
          res_valid = 1'b1;
          if (!verified_r) begin
            if (plen >= CW'(crcfp_pkg::IdLen) && id_match_r) begin
              verified_nxt = 1'b1;
              res.kind     = crcfp_pkg::KIND_IDENTITY;
            end
          end else if (cmd_r == crcfp_pkg::DistCmd && plen >= CW'(4)
                       && dist_r < crcfp_pkg::DistLimit) begin
            res.kind        = crcfp_pkg::KIND_DISTANCE;
            res.distance_cm = dist_r[14:0];
          end
          res.sensor_verified = verified_nxt;
        end
      end
      default: begin
        // Hunting, and any phase code that means nothing.
        body_nxt  = '0;
        count_nxt = '0;
        phase_nxt = crcfp_pkg::PH_HUNT;
        if (rx_byte == start_marker) begin
          crc_nxt   = crcfp_pkg::crc_step(16'h0000, rx_byte);
          phase_nxt = crcfp_pkg::PH_FLAGS_LO;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= crcfp_pkg::PH_HUNT;
      body_r     <= '0;
      count_r    <= '0;
      cmd_r      <= '0;
      crc_r      <= '0;
      crc_lo_r   <= '0;
      id_match_r <= 1'b1;
      dist_r     <= '0;
      verified_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      body_r     <= body_nxt;
      count_r    <= count_nxt;
      cmd_r      <= cmd_nxt;
      crc_r      <= crc_nxt;
      crc_lo_r   <= crc_lo_nxt;
      id_match_r <= id_match_nxt;
      dist_r     <= dist_nxt;
      verified_r <= verified_nxt;
    end
  end

  a_result_only_at_crc_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> phase_r == crcfp_pkg::PH_CRC_HI)
    else $error("result raised outside the CRC high byte");

  a_verified_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    verified_r |=> verified_r)
    else $error("verified flag cleared");

  a_distance_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == crcfp_pkg::KIND_DISTANCE)
      |-> (verified_r && cmd_r == crcfp_pkg::DistCmd && dist_r < crcfp_pkg::DistLimit))
    else $error("distance reported without verification or in range");

endmodule

`default_nettype wire

// ===== sv/crcfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// crcfp_out_reg
// Result register; loads a finished frame result and holds it while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfp_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic               load_valid,
  input  wire crcfp_pkg::result_t load_res,
  output logic                    free,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output crcfp_pkg::result_t      out_res
);

  logic               valid_r, valid_nxt;
  crcfp_pkg::result_t res_r,   res_nxt;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = load_valid;
      res_nxt   = load_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/crc_checked_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// crc_checked_frame_parser_core
// Byte-stream deframer with CRC-16 check, identity latch and distance decode.
// ----------------------------------------------------------------------------
// Usage: received serial bytes enter on the in_ channel (in_valid/in_stall),
// one byte per beat. Frame results leave on the out_ channel
// (out_valid/out_stall), one beat per frame whose CRC checks out; bytes that
// complete no frame produce nothing. The cfg_ channel writes the start marker
// byte; cfg_ready is always high and writes belong to idle periods.
// Throughput is one byte per cycle while the out_ channel does not stall.
// A byte is parsed while it sits in the input register and its outcome loads
// the result register at the edge where the parser takes it; out_valid rises
// once the last byte of a frame has passed both registers. The parse state
// advances only when the result register can take the outcome of the byte.
// While the out_ channel stalls a result, the input register holds at most
// one more byte and then stalls the sender; that byte is parsed at the edge
// where the result is taken.
// Reset (rst_n low at a clock edge) empties both registers, returns the parser
// to hunting, clears the verified flag and restores the marker to 0xAA.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_checked_frame_parser_core #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_command_id,
  output logic [6:0]       out_payload_length,
  output logic [14:0]      out_distance_cm,
  output logic             out_sensor_verified,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_start_marker
);

  logic               hold_valid;
  logic [7:0]         hold_byte;
  logic               out_free;
  logic               step;
  logic               res_valid;
  crcfp_pkg::result_t res;
  crcfp_pkg::result_t out_res;
  logic [7:0]         marker_r, marker_nxt;

  assign cfg_ready  = 1'b1;
  assign marker_nxt = (cfg_valid && cfg_ready) ? cfg_start_marker : marker_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= crcfp_pkg::MarkerReset;
    end else begin
      marker_r <= marker_nxt;
    end
  end

  assign step = hold_valid && out_free;

  crcfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (step),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  crcfp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (hold_byte),
    .start_marker (marker_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  crcfp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .load_valid (res_valid),
    .load_res   (res),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_result_kind     = out_res.kind;
  assign out_command_id      = out_res.command_id;
  assign out_payload_length  = out_res.payload_length;
  assign out_distance_cm     = out_res.distance_cm;
  assign out_sensor_verified = out_res.sensor_verified;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (hold_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed or dropped");

  a_result_next_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid) |=> out_valid)
    else $error("finished frame did not reach the result register");

endmodule

`default_nettype wire
